### design/triangle_pixel_depth_test_macros.svh
// ----------------------------------------------------------------------------
// Triangle pixel depth test assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_DEPTH_TEST_MACROS_SVH
`define TRIANGLE_PIXEL_DEPTH_TEST_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TPDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpdt assertion failed");

// Antecedent implies consequent in the next cycle.
`define TPDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpdt assertion failed");

`endif

### design/tpdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel depth test package
// Transfer types, queue entry type and fixed widths shared by all modules.
// ----------------------------------------------------------------------------
package tpdt_pkg;

    localparam int unsigned NUM_W   = 48;
    localparam int unsigned DEN_W   = 27;
    localparam int unsigned DEPTH_W = 17;
    localparam int unsigned QUO_W   = 17;
    localparam logic [16:0] DEPTH_FAR = 17'h10000;

    typedef struct packed {
        logic               req_type;
        logic signed [11:0] pix_x;
        logic signed [11:0] pix_y;
        logic signed [11:0] vert_a_x;
        logic signed [11:0] vert_a_y;
        logic signed [11:0] vert_b_x;
        logic signed [11:0] vert_b_y;
        logic signed [11:0] vert_c_x;
        logic signed [11:0] vert_c_y;
        logic [15:0]        recip_w_a;
        logic [15:0]        recip_w_b;
        logic [15:0]        recip_w_c;
    } in_item_t;

    typedef struct packed {
        logic        write_pixel;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [31:0] out_color;
        logic [16:0] out_depth;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TEST
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [11:0]              x;
        logic [11:0]              y;
        logic signed [NUM_W-1:0]  num;
        logic [DEN_W-1:0]         den;
    } job_t;

endpackage

### design/tpdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel depth test front end
// Accepts requests, sorts out clears and skipped pixels, and forms the
// depth numerator and divisor over the cross, mix and sum stages.
// ----------------------------------------------------------------------------
module tpdt_front #(
    parameter int unsigned FB_WIDTH  = 64,
    parameter int unsigned FB_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpdt_pkg::in_item_t in_data,
    input  logic              init_busy,
    output logic              push,
    output tpdt_pkg::job_t    push_job,
    input  logic              q_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_CROSS,
        F_MIX,
        F_SUM,
        F_PUSH
    } fstate_t;

    fstate_t state_reg, state_next;

    logic signed [12:0] cax_reg, cay_reg, bax_reg, bay_reg;
    logic signed [12:0] cpx_reg, cpy_reg, bpx_reg, bpy_reg, pax_reg, pay_reg;
    logic signed [26:0] area_reg, wa_reg, wb_reg;
    logic signed [28:0] wc;
    logic signed [45:0] pa_reg, pb_reg, pc_reg;
    logic [15:0]        ra_reg, rb_reg, rc_reg;
    logic signed [47:0] sum, num;
    tpdt_pkg::job_t     job_reg;
    logic               in_win;
    logic               take;

    assign in_ready = (state_reg == F_IDLE) && !init_busy;
    assign take     = in_valid && in_ready;
    assign in_win   = !in_data.pix_x[11] && !in_data.pix_y[11]
                      && ({1'b0, in_data.pix_x} < 13'(FB_WIDTH))
                      && ({1'b0, in_data.pix_y} < 13'(FB_HEIGHT));
    assign push     = (state_reg == F_PUSH) && !q_full;
    assign push_job = job_reg;

    assign wc  = 29'(area_reg) - 29'(wa_reg) - 29'(wb_reg);
    assign sum = 48'(pa_reg) + 48'(pb_reg) + 48'(pc_reg);
    assign num = (48'(area_reg) <<< 16) - sum;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    state_next = (in_win && !in_data.req_type) ? F_CROSS : F_PUSH;
                end
            end
            F_CROSS: state_next = F_MIX;
            F_MIX:   state_next = (area_reg == '0) ? F_PUSH : F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg.x   <= in_data.pix_x;
            job_reg.y   <= in_data.pix_y;
            job_reg.num <= '0;
            job_reg.den <= '0;
            if (!in_win)
            begin
                job_reg.op <= tpdt_pkg::OP_NOP;
            end
            else if (in_data.req_type)
            begin
                job_reg.op <= tpdt_pkg::OP_CLEAR;
            end
            else
            begin
                job_reg.op <= tpdt_pkg::OP_TEST;
            end
            cax_reg <= 13'(in_data.vert_c_x) - 13'(in_data.vert_a_x);
            cay_reg <= 13'(in_data.vert_c_y) - 13'(in_data.vert_a_y);
            bax_reg <= 13'(in_data.vert_b_x) - 13'(in_data.vert_a_x);
            bay_reg <= 13'(in_data.vert_b_y) - 13'(in_data.vert_a_y);
            cpx_reg <= 13'(in_data.vert_c_x) - 13'(in_data.pix_x);
            cpy_reg <= 13'(in_data.vert_c_y) - 13'(in_data.pix_y);
            bpx_reg <= 13'(in_data.vert_b_x) - 13'(in_data.pix_x);
            bpy_reg <= 13'(in_data.vert_b_y) - 13'(in_data.pix_y);
            pax_reg <= 13'(in_data.pix_x) - 13'(in_data.vert_a_x);
            pay_reg <= 13'(in_data.pix_y) - 13'(in_data.vert_a_y);
            ra_reg  <= in_data.recip_w_a;
            rb_reg  <= in_data.recip_w_b;
            rc_reg  <= in_data.recip_w_c;
        end
        if (state_reg == F_CROSS)
        begin
            area_reg <= 27'(cax_reg) * 27'(bay_reg) - 27'(cay_reg) * 27'(bax_reg);
            wa_reg   <= 27'(cpx_reg) * 27'(bpy_reg) - 27'(cpy_reg) * 27'(bpx_reg);
            wb_reg   <= 27'(cax_reg) * 27'(pay_reg) - 27'(cay_reg) * 27'(pax_reg);
        end
        if (state_reg == F_MIX)
        begin
            pa_reg <= 46'($signed({1'b0, ra_reg})) * 46'(wa_reg);
            pb_reg <= 46'($signed({1'b0, rb_reg})) * 46'(wb_reg);
            pc_reg <= 46'($signed({1'b0, rc_reg})) * 46'(wc);
            if (area_reg == '0)
            begin
                job_reg.op <= tpdt_pkg::OP_NOP;
            end
        end
        if (state_reg == F_SUM)
        begin
            job_reg.num <= area_reg[26] ? -num : num;
            job_reg.den <= area_reg[26] ? 27'(-area_reg) : 27'(area_reg);
        end
    end

endmodule

### design/tpdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel depth test job queue
// Two-entry queue that decouples the front end from the depth back end.
// ----------------------------------------------------------------------------
module tpdt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpdt_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tpdt_pkg::job_t head
);

    tpdt_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end

endmodule

### design/tpdt_back.sv
`timescale 1ns / 1ps
`include "triangle_pixel_depth_test_macros.svh"
// ----------------------------------------------------------------------------
// Triangle pixel depth test back end
// Clears the depth memory after reset, divides out the depth, tests and
// updates the depth memory, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tpdt_back #(
    parameter int unsigned FB_WIDTH  = 64,
    parameter int unsigned FB_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  tpdt_pkg::job_t     q_head,
    output logic               q_pop,
    output logic               init_busy,
    input  logic [31:0]        fill_color,
    output logic               out_valid,
    input  logic               out_ready,
    output tpdt_pkg::out_item_t out_data
);

    localparam int unsigned DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DW    = tpdt_pkg::DEN_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CMP,
        S_OUT
    } bstate_t;

    bstate_t state_reg;
    logic [4:0]              cnt_reg;
    logic [IDX_W-1:0]        clr_idx_reg;
    tpdt_pkg::job_t          job_reg;
    logic [DW:0]             rem_reg;
    logic [16:0]             numlo_reg;
    logic [16:0]             q_reg;
    logic                    neg_reg, sat_reg;
    logic [16:0]             rd_reg;
    logic [16:0]             mem [DEPTH];
    logic                    out_valid_reg;
    tpdt_pkg::out_item_t     out_reg, res_reg;

    logic [IDX_W-1:0]        idx;
    logic [DW+1:0]           trial;
    logic                    ge;
    logic [16:0]             depth;
    logic                    pass;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [16:0]             wdata;
    logic [46:0]             mag;
    tpdt_pkg::out_item_t     res_next;

    assign idx   = IDX_W'(24'(job_reg.y) * 24'(FB_WIDTH) + 24'(job_reg.x));
    assign trial = {rem_reg, numlo_reg[16]};
    assign ge    = (trial >= (DW + 2)'(job_reg.den));
    assign depth = neg_reg ? 17'd0
                 : (sat_reg || (q_reg > tpdt_pkg::DEPTH_FAR)) ? tpdt_pkg::DEPTH_FAR
                 : q_reg;
    assign pass  = (job_reg.op == tpdt_pkg::OP_TEST) && (depth < rd_reg);
    assign mag   = q_head.num[46:0];

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign init_busy = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = idx;
        wdata = tpdt_pkg::DEPTH_FAR;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
        end
        else if (state_reg == S_CMP)
        begin
            if (job_reg.op == tpdt_pkg::OP_CLEAR)
            begin
                we = 1'b1;
            end
            else if (pass)
            begin
                we    = 1'b1;
                wdata = depth;
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        if (pass)
        begin
            res_next.write_pixel = 1'b1;
            res_next.out_x       = job_reg.x;
            res_next.out_y       = job_reg.y;
            res_next.out_color   = fill_color;
            res_next.out_depth   = depth;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (!q_empty)
                    begin
                        state_reg <= (q_head.op == tpdt_pkg::OP_TEST) ? S_DIV : S_CMP;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(tpdt_pkg::QUO_W - 1))
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg   <= q_head;
            neg_reg   <= q_head.num[tpdt_pkg::NUM_W-1];
            sat_reg   <= (mag[46:17] >= 30'(q_head.den));
            rem_reg   <= (DW + 1)'(mag[46:17]);
            numlo_reg <= mag[16:0];
            q_reg     <= '0;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg   <= ge ? (DW + 1)'(trial - (DW + 2)'(job_reg.den)) : (DW + 1)'(trial);
            numlo_reg <= {numlo_reg[15:0], 1'b0};
            q_reg     <= {q_reg[15:0], ge};
        end
        if (state_reg == S_CMP)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            out_reg <= res_reg;
        end
    end

    `TPDT_ASSERT_IMP(a_pop_only_idle, q_pop, (state_reg == S_IDLE) && !init_busy)
    `TPDT_ASSERT_IMP(a_div_bound, state_reg == S_DIV, cnt_reg < 5'(tpdt_pkg::QUO_W))
    `TPDT_ASSERT_IMP(a_write_nearer, out_valid && out_data.write_pixel, out_data.out_depth != tpdt_pkg::DEPTH_FAR)
    `TPDT_ASSERT_NXT(a_cmp_to_out, state_reg == S_CMP, state_reg == S_OUT)

endmodule

### design/triangle_pixel_depth_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel depth test
// After reset the block sets every stored depth to far and accepts no
// request meanwhile. A test request then passes through the front end and
// the back end, where a 17-step restoring divider and the depth memory
// read-modify-write set the pace; the back end works on one test pixel at a
// time, while the front end may take the next request. Clears and skipped
// pixels bypass the divider. Every request yields exactly one result
// transfer, all zero when nothing is written.
// ----------------------------------------------------------------------------
module triangle_pixel_depth_test #(
    parameter int unsigned FB_WIDTH  = 64,
    parameter int unsigned FB_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpdt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tpdt_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0]    fill_color_reg;
    logic           init_busy;
    logic           push, q_full, q_pop, q_empty;
    tpdt_pkg::job_t push_job, q_head;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? fill_color_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg <= 32'hFFFF_FFFF;
        end
        else if (psel && penable && pwrite && (paddr == 3'd0))
        begin
            fill_color_reg <= pwdata;
        end
    end

    tpdt_front #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .init_busy (init_busy),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    tpdt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    tpdt_back #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .init_busy  (init_busy),
        .fill_color (fill_color_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
